// ===== hw/rtl/line_path_resampler_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the line path resampler
// Clocked property shorthands shared by the block's assertions.
// ---------------------------------------------------------------------------
`ifndef LINE_PATH_RESAMPLER_TOP_ASSERT_SVH
`define LINE_PATH_RESAMPLER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define LPR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LPR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lpr_pkg.sv =====
// ---------------------------------------------------------------------------
// Line path resampler package
// Widths, step counts, the step limit and the sequencer state type.
// ---------------------------------------------------------------------------
package lpr_pkg;

    localparam int COORD_W   = 32;
    localparam int SPACING_W = 31;
    localparam int N_W       = 6;

    // largest step count; a run holds at most MAX_SEGMENTS + 2 items
    localparam logic [N_W-1:0] MAX_SEGMENTS = 6'd62;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 31'd65536;

    // last value of the loop counter in each serial phase
    localparam logic [5:0] MUL_LAST  = 6'd31;   // 32 multiplier bits
    localparam logic [5:0] SQRT_LAST = 6'd32;   // 33 root bits
    localparam logic [5:0] DIVN_LAST = 6'd32;   // 33 quotient bits
    localparam logic [5:0] DIVS_LAST = 6'd31;   // 32 quotient bits

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_SQRT = 6'b000100,
        ST_DIVN = 6'b001000,
        ST_DIVS = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

endpackage

// ===== hw/rtl/line_path_resampler_top.sv =====
// ---------------------------------------------------------------------------
// Line path resampler
// Samples a segment at roughly fixed spacing: length by bit-serial square
// root, step count by bit-serial division, then start, step points and end.
// ---------------------------------------------------------------------------
//  channel | direction | item
//  s_      | in        | start_x, start_y, end_x, end_y (signed Q16.16)
//  m_      | out       | point_x, point_y (signed Q16.16), last as tlast
//  cfg_    | in        | spacing (unsigned Q15.16), written on cfg_wen
//
//  Each item passes through serial multiply, square root, count division and
//  step division, one bit per cycle (zero spacing skips the count division),
//  then n + 2 output items, one per cycle while m_tready stays high, then the
//  idle state, in which the next item is taken.
//  s_tready is high only between runs; the end point may still wait in the
//  output register while the next item is taken. Sync active-low reset.
// ---------------------------------------------------------------------------
module line_path_resampler_top (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_wen,
    input  logic [30:0]  cfg_wdata,      // spacing
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,        // start_x, start_y, end_x, end_y
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,        // point_x, point_y
    output logic         m_tlast
);

    lpr_pkg::state_t state_reg, state_next;

    logic [lpr_pkg::SPACING_W-1:0] spacing_reg, spacing_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic [31:0] sx_reg, sx_next, sy_reg, sy_next;
    logic [31:0] ex_reg, ex_next, ey_reg, ey_next;
    logic [31:0] ax_reg, ax_next, ay_reg, ay_next;
    logic        negx_reg, negx_next, negy_reg, negy_next;

    // multiplier bits, later step dividend / quotient
    logic [31:0] mbx_reg, mbx_next, mby_reg, mby_next;
    // product accumulator, later square root radicand
    logic [65:0] mac_reg, mac_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] root_reg, root_next;
    logic [30:0] drem_reg, drem_next;
    logic [5:0]  q_reg, q_next;
    logic        sat_reg, sat_next;
    logic [5:0]  srx_reg, srx_next, sry_reg, sry_next;
    logic [31:0] accx_reg, accx_next, accy_reg, accy_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;

    // accept-time differences
    logic [32:0] dx, dy;
    logic [32:0] dx_mag, dy_mag;

    // serial datapath terms
    logic [34:0] mul_sum;
    logic [35:0] sq_sh, sq_trial, sq_diff;
    logic        sq_ge;
    logic [31:0] dn_sh, dn_diff;
    logic        dn_ge;
    logic [6:0]  q_ext;
    logic [5:0]  n_val;
    logic [6:0]  dsx_sh, dsy_sh, dsx_diff, dsy_diff;
    logic        dsx_ge, dsy_ge;
    logic [31:0] step_x, step_y;
    logic [31:0] nxt_x, nxt_y;

    logic        in_acc;
    logic        out_free;
    logic        emit_load;
    logic        last_pt;

    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // differences and magnitudes, 33 bits so nothing wraps
    assign dx     = {s_tdata[95], s_tdata[95:64]} - {s_tdata[31], s_tdata[31:0]};
    assign dy     = {s_tdata[127], s_tdata[127:96]} - {s_tdata[63], s_tdata[63:32]};
    assign dx_mag = dx[32] ? 33'(33'd0 - dx) : dx;
    assign dy_mag = dy[32] ? 33'(33'd0 - dy) : dy;

    // sum of squares: both products share one right-shifting accumulator
    assign mul_sum = 35'(mac_reg[65:32])
                   + (mbx_reg[0] ? {3'b000, ax_reg} : 35'd0)
                   + (mby_reg[0] ? {3'b000, ay_reg} : 35'd0);

    // restoring square root, two radicand bits per cycle
    assign sq_sh    = {rem_reg, mac_reg[65:64]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_diff  = sq_sh - sq_trial;

    // length / spacing, one quotient bit per cycle, saturating count
    assign dn_sh   = {drem_reg, root_reg[32]};
    assign dn_ge   = dn_sh >= {1'b0, spacing_reg};
    assign dn_diff = dn_sh - {1'b0, spacing_reg};
    assign q_ext   = {q_reg, dn_ge};
    assign n_val   = sat_reg ? lpr_pkg::MAX_SEGMENTS : q_reg;

    // per-axis step magnitude = |d| / n, one bit per cycle
    assign dsx_sh   = {srx_reg, mbx_reg[31]};
    assign dsy_sh   = {sry_reg, mby_reg[31]};
    assign dsx_ge   = dsx_sh >= {1'b0, n_val};
    assign dsy_ge   = dsy_sh >= {1'b0, n_val};
    assign dsx_diff = dsx_sh - {1'b0, n_val};
    assign dsy_diff = dsy_sh - {1'b0, n_val};

    // signed step, truncated toward zero
    assign step_x = negx_reg ? 32'(32'd0 - mbx_reg) : mbx_reg;
    assign step_y = negy_reg ? 32'(32'd0 - mby_reg) : mby_reg;
    assign nxt_x  = accx_reg + step_x;
    assign nxt_y  = accy_reg + step_y;

    assign emit_load = (state_reg == lpr_pkg::ST_EMIT) && out_free;
    assign last_pt   = 7'(cnt_reg) > 7'(n_val);

    // sequencer and datapath next state
    always_comb begin
        state_next    = state_reg;
        spacing_next  = spacing_reg;
        cnt_next      = cnt_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        negx_next     = negx_reg;
        negy_next     = negy_reg;
        mbx_next      = mbx_reg;
        mby_next      = mby_reg;
        mac_next      = mac_reg;
        rem_next      = rem_reg;
        root_next     = root_reg;
        drem_next     = drem_reg;
        q_next        = q_reg;
        sat_next      = sat_reg;
        srx_next      = srx_reg;
        sry_next      = sry_reg;
        accx_next     = accx_reg;
        accy_next     = accy_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (cfg_wen) begin
            spacing_next = cfg_wdata;
        end

        // output register drains when taken
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            lpr_pkg::ST_IDLE: begin
                if (in_acc) begin
                    sx_next    = s_tdata[31:0];
                    sy_next    = s_tdata[63:32];
                    ex_next    = s_tdata[95:64];
                    ey_next    = s_tdata[127:96];
                    ax_next    = dx_mag[31:0];
                    ay_next    = dy_mag[31:0];
                    negx_next  = dx[32];
                    negy_next  = dy[32];
                    mbx_next   = dx_mag[31:0];
                    mby_next   = dy_mag[31:0];
                    mac_next   = '0;
                    accx_next  = s_tdata[31:0];
                    accy_next  = s_tdata[63:32];
                    cnt_next   = '0;
                    state_next = lpr_pkg::ST_MUL;
                end
            end
            lpr_pkg::ST_MUL: begin
                mac_next = {mul_sum, mac_reg[31:1]};
                mbx_next = {1'b0, mbx_reg[31:1]};
                mby_next = {1'b0, mby_reg[31:1]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == lpr_pkg::MUL_LAST) begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = lpr_pkg::ST_SQRT;
                end
            end
            lpr_pkg::ST_SQRT: begin
                rem_next  = sq_ge ? sq_diff[33:0] : sq_sh[33:0];
                root_next = {root_reg[31:0], sq_ge};
                mac_next  = {mac_reg[63:0], 2'b00};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == lpr_pkg::SQRT_LAST) begin
                    drem_next = '0;
                    q_next    = '0;
                    cnt_next  = '0;
                    if (spacing_reg == '0) begin
                        // zero spacing: step count goes straight to the limit
                        sat_next   = 1'b1;
                        mbx_next   = ax_reg;
                        mby_next   = ay_reg;
                        srx_next   = '0;
                        sry_next   = '0;
                        state_next = lpr_pkg::ST_DIVS;
                    end else begin
                        sat_next   = 1'b0;
                        state_next = lpr_pkg::ST_DIVN;
                    end
                end
            end
            lpr_pkg::ST_DIVN: begin
                drem_next = dn_ge ? dn_diff[30:0] : dn_sh[30:0];
                root_next = {root_reg[31:0], 1'b0};
                if (sat_reg || q_ext > 7'(lpr_pkg::MAX_SEGMENTS)) begin
                    sat_next = 1'b1;
                end else begin
                    q_next = q_ext[5:0];
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == lpr_pkg::DIVN_LAST) begin
                    mbx_next   = ax_reg;
                    mby_next   = ay_reg;
                    srx_next   = '0;
                    sry_next   = '0;
                    cnt_next   = '0;
                    state_next = lpr_pkg::ST_DIVS;
                end
            end
            lpr_pkg::ST_DIVS: begin
                // with a zero count the quotient is never used
                srx_next = dsx_ge ? dsx_diff[5:0] : dsx_sh[5:0];
                sry_next = dsy_ge ? dsy_diff[5:0] : dsy_sh[5:0];
                mbx_next = {mbx_reg[30:0], dsx_ge};
                mby_next = {mby_reg[30:0], dsy_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == lpr_pkg::DIVS_LAST) begin
                    cnt_next   = '0;
                    state_next = lpr_pkg::ST_EMIT;
                end
            end
            lpr_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    cnt_next      = cnt_reg + 6'd1;
                    if (last_pt) begin
                        m_tdata_next = {ey_reg, ex_reg};
                        m_tlast_next = 1'b1;
                        state_next   = lpr_pkg::ST_IDLE;
                    end else if (cnt_reg == '0) begin
                        m_tdata_next = {sy_reg, sx_reg};
                        m_tlast_next = 1'b0;
                    end else begin
                        m_tdata_next = {nxt_y, nxt_x};
                        m_tlast_next = 1'b0;
                        accx_next    = nxt_x;
                        accy_next    = nxt_y;
                    end
                end
            end
            default: begin
                state_next = lpr_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lpr_pkg::ST_IDLE;
            spacing_reg  <= lpr_pkg::SPACING_RESET;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            spacing_reg  <= spacing_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        ex_reg      <= ex_next;
        ey_reg      <= ey_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        negx_reg    <= negx_next;
        negy_reg    <= negy_next;
        mbx_reg     <= mbx_next;
        mby_reg     <= mby_next;
        mac_reg     <= mac_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        drem_reg    <= drem_next;
        q_reg       <= q_next;
        sat_reg     <= sat_next;
        srx_reg     <= srx_next;
        sry_reg     <= sry_next;
        accx_reg    <= accx_next;
        accy_reg    <= accy_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign s_tready = (state_reg == lpr_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // checks
`include "line_path_resampler_top_assert.svh"

    `LPR_ASSERT_NEXT(a_accept_starts, aclk, aresetn, in_acc, state_reg == lpr_pkg::ST_MUL, "accepted item did not start the multiply")
    `LPR_ASSERT_SAME(a_emit_count, aclk, aresetn, state_reg == lpr_pkg::ST_EMIT, 7'(cnt_reg) <= 7'(n_val) + 7'd1, "point counter ran past the end point")
    `LPR_ASSERT_NEXT(a_last_ends_run, aclk, aresetn, emit_load && last_pt, state_reg == lpr_pkg::ST_IDLE && m_tvalid && m_tlast, "end point did not close the run")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Line path resampler testbench
// Sends segments, predicts every path point from its own model of the
// block and checks each point taken from the result stream, in order, field
// by field. A directed table comes first, then random segments under
// several spacings, with random idling, a long output hold-off and a
// sender pause until all points have been taken.
// ---------------------------------------------------------------------------
module tb;

    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ONE   = 32'sd65536;
    localparam logic [30:0]        SP_ONE = lpr_pkg::SPACING_RESET;

    localparam int IDLE_PCT    = 29;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;
    localparam int PHASE_ITEMS = 28;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } segment_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
    } path_point_t;

    // direct rows hold no steps, so the points are just start then end
    typedef struct packed {
        logic [30:0] spacing;
        segment_t    seg;
        logic        direct;
    } directed_row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_wen;
    logic [30:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;      // start_x, start_y, end_x, end_y
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;      // point_x, point_y
    logic         m_tlast;

    path_point_t  path_points[$];
    logic [30:0]  spacing_now = SP_ONE;
    int           mismatches  = 0;
    int unsigned  quiet_cycles = 0;
    bit           calm = 1'b0;
    bit           hold_req = 1'b0;

    directed_row_t directed_rows [20] = '{
        '{SP_ONE, '{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1},
        '{SP_ONE, '{32'sd0, 32'sd0, 32'sh8000, 32'sd0}, 1'b1},
        '{SP_ONE, '{32'sd0, 32'sd0, 3 * ONE, 4 * ONE}, 1'b0},
        '{SP_ONE, '{-5 * ONE, 2 * ONE, 5 * ONE, -2 * ONE}, 1'b0},
        '{SP_ONE, '{C_MIN, C_MIN, C_MAX, C_MAX}, 1'b0},
        '{SP_ONE, '{C_MAX, C_MIN, C_MIN, C_MAX}, 1'b0},
        '{SP_ONE, '{C_MIN, 32'sd0, C_MAX, 32'sd0}, 1'b0},
        '{SP_ONE, '{32'sd0, C_MAX, 32'sd0, C_MIN}, 1'b0},
        '{31'd1, '{32'sd0, 32'sd0, 32'sd1, 32'sd0}, 1'b0},
        '{31'd1, '{32'sd0, 32'sd0, 32'sd100, -32'sd37}, 1'b0},
        '{31'd1, '{-32'sd1, -32'sd1, -32'sd1, -32'sd1}, 1'b1},
        '{31'h7FFF_FFFF, '{32'sd0, 32'sd0, C_MAX, 32'sd0}, 1'b0},
        '{31'h7FFF_FFFF, '{C_MIN, C_MIN, C_MAX, C_MAX}, 1'b0},
        '{31'h7FFF_FFFF, '{32'sd0, 32'sd0, 32'sh7FFF_FFFE, 32'sd0}, 1'b1},
        '{31'd0, '{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0},
        '{31'd0, '{32'sd1, 32'sd2, -32'sd70, 32'sd5}, 1'b0},
        '{31'd196608, '{32'sd0, 32'sd0, 10 * ONE, 32'sd0}, 1'b0},
        '{31'd196608, '{32'sd0, 32'sd0, -10 * ONE - 1, 32'sd7}, 1'b0},
        '{31'd196608, '{32'sd7, 32'sd7, 32'sd0, -32'sd1}, 1'b1},
        '{31'd196608, '{C_MAX, C_MAX, C_MAX - 4 * ONE, C_MAX - 3 * ONE}, 1'b0}
    };

    line_path_resampler_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Append one expected point behind the others
    function automatic void expect_point(input path_point_t pt);
        path_points.insert(path_points.size(), pt);
    endfunction

    // Expected path of one segment: floor root of the squared length, step
    // count saturated, per-axis step truncated toward zero
    function automatic void trace_segment(input segment_t seg);
        longint      dx, dy, steps, step_x, step_y;
        logic [65:0] ax, ay, sum_sq, trial_sq;
        logic [32:0] root, trial;
        dx = longint'(seg.ex) - longint'(seg.sx);
        dy = longint'(seg.ey) - longint'(seg.sy);
        ax = 66'(dx < 0 ? -dx : dx);
        ay = 66'(dy < 0 ? -dy : dy);
        sum_sq = ax * ax + ay * ay;
        root = '0;
        for (int b = 32; b >= 0; b--) begin
            trial    = root | (33'd1 << b);
            trial_sq = 66'(trial) * 66'(trial);
            if (trial_sq <= sum_sq)
                root = trial;
        end
        if (spacing_now == '0)
            steps = longint'(lpr_pkg::MAX_SEGMENTS);
        else
            steps = longint'(root) / longint'(spacing_now);
        if (steps > longint'(lpr_pkg::MAX_SEGMENTS))
            steps = longint'(lpr_pkg::MAX_SEGMENTS);
        expect_point('{x: seg.sx, y: seg.sy, last: 1'b0});
        if (steps > 0) begin
            step_x = dx / steps;
            step_y = dy / steps;
            for (longint i = 1; i <= steps; i++)
                expect_point('{x: 32'(longint'(seg.sx) + i * step_x),
                               y: 32'(longint'(seg.sy) + i * step_y),
                               last: 1'b0});
        end
        expect_point('{x: seg.ex, y: seg.ey, last: 1'b1});
    endfunction

    function automatic logic signed [31:0] corner_coord();
        case ($urandom_range(5))
            0: return C_MIN;
            1: return C_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return ONE;
        endcase
    endfunction

    // Mostly segments whose length lands within reach of the step limit,
    // with some fully random and some corner-valued ones
    function automatic segment_t random_segment(input logic [30:0] spacing);
        segment_t    seg;
        longint      reach, dx, dy;
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 2) begin
            seg = {$urandom(), $urandom(), $urandom(), $urandom()};
        end else if (pick == 9) begin
            seg = {corner_coord(), corner_coord(), corner_coord(), corner_coord()};
        end else begin
            reach = longint'(spacing) * $urandom_range(70) + $urandom_range(spacing);
            if (reach > (64'sd1 << 30))
                reach = 64'sd1 << 30;
            seg.sx = $signed($urandom()) >>> 1;
            seg.sy = $signed($urandom()) >>> 1;
            dx = longint'($urandom_range(32'(reach)));
            dy = longint'($urandom_range(32'(reach)));
            if ($urandom_range(1)) dx = -dx;
            if ($urandom_range(1)) dy = -dy;
            seg.ex = 32'(longint'(seg.sx) + dx);
            seg.ey = 32'(longint'(seg.sy) + dy);
        end
        return seg;
    endfunction

    // Offer one segment after a random gap and return once it is taken
    task automatic offer_segment(input segment_t seg);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {seg.ey, seg.ex, seg.sy, seg.sx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_path_done();
        s_tvalid <= 1'b0;
        while (path_points.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_spacing(input logic [30:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen     <= 1'b0;
        spacing_now = value;
    endtask

    // Result side: random back-pressure, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Point check against the oldest expectation
    always @(posedge aclk) begin : point_check
        path_point_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{x: m_tdata[31:0], y: m_tdata[63:32], last: m_tlast};
            if (path_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point: x=%0d y=%0d last=%0b",
                             got.x, got.y, got.last);
            end else begin
                want = path_points.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point mismatch: want x=%0d y=%0d last=%0b, %s",
                                 want.x, want.y, want.last,
                                 $sformatf("got x=%0d y=%0d last=%0b",
                                           got.x, got.y, got.last));
                end
            end
        end
    end

    // Watchdog: cycles with no item taken on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        segment_t    seg;
        logic [30:0] phase_spacing;
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table; spacing changes only once the path is drained
        foreach (directed_rows[r]) begin
            if (directed_rows[r].spacing != spacing_now) begin
                wait_path_done();
                write_spacing(directed_rows[r].spacing);
            end
            seg = directed_rows[r].seg;
            offer_segment(seg);
            if (directed_rows[r].direct) begin
                expect_point('{x: seg.sx, y: seg.sy, last: 1'b0});
                expect_point('{x: seg.ex, y: seg.ey, last: 1'b1});
            end else begin
                trace_segment(seg);
            end
        end

        // random phases: fine, coarse, any and unit spacing
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: phase_spacing = 31'($urandom_range(1, 1 << 18));
                1: phase_spacing = 31'($urandom_range(1 << 18, 1 << 24));
                2: phase_spacing = 31'($urandom());
                default: phase_spacing = SP_ONE;
            endcase
            wait_path_done();
            write_spacing(phase_spacing);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                calm = (phase == 2 && k < 20);
                if (phase == 1 && k == 3)
                    hold_req = 1'b1;
                if (phase == 3 && k == 15)
                    wait_path_done();
                seg = random_segment(phase_spacing);
                offer_segment(seg);
                trace_segment(seg);
            end
        end
        calm = 1'b0;

        wait_path_done();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && path_points.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lpr_pkg.sv
hw/rtl/line_path_resampler_top.sv
bench/tb.sv
